### rtl/dsnp_pkg.sv
// shared types and constants for the decimal string number parser
`default_nettype none

package dsnp_pkg;

  localparam int ACC_WIDTH_DEF = 32;
  localparam int CHAR_W        = 8;
  localparam int VAL_W         = 32;
  localparam int CNT_W         = 8;
  localparam int OUT_DATA_W    = 2 * VAL_W + CNT_W;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

  typedef enum logic [1:0] {
    PH_SEEK = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [CHAR_W-1:0] code;
  } char_slot_t;

endpackage

`default_nettype wire

### rtl/dsnp_in_reg.sv
// input register stage holding one character between the slave port and the parser core
`default_nettype none

module dsnp_in_reg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [dsnp_pkg::CHAR_W-1:0] in_tdata,
  input  wire logic                       in_tlast,
  input  wire logic                       take,
  output dsnp_pkg::char_slot_t            slot
);

  dsnp_pkg::char_slot_t slot_r;
  dsnp_pkg::char_slot_t slot_nxt;

  assign in_tready = !slot_r.valid || take;
  assign slot      = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (in_tready) begin
      slot_nxt.valid = in_tvalid;
      slot_nxt.last  = in_tlast;
      slot_nxt.code  = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
    slot_r.last <= slot_nxt.last;
    slot_r.code <= slot_nxt.code;
  end

endmodule

`default_nettype wire

### rtl/dsnp_core.sv
// parse step, accumulator state and result register
`default_nettype none

module dsnp_core #(
  parameter int ACC_WIDTH = dsnp_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dsnp_pkg::char_slot_t          slot,
  output logic                               take,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [dsnp_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser
);

  dsnp_pkg::phase_t phase_r, phase_nxt;
  logic [ACC_WIDTH-1:0]         int_acc_r, int_acc_nxt, int_step;
  logic [ACC_WIDTH-1:0]         frac_acc_r, frac_acc_nxt, frac_step;
  logic [dsnp_pkg::CNT_W-1:0]   frac_cnt_r, frac_cnt_nxt, frac_cnt_step;
  logic                         sign_r, sign_nxt, sign_step;
  logic [ACC_WIDTH-1:0]         digit;
  logic                         is_digit;
  logic                         out_free;
  logic                         out_load;
  logic                         out_valid_r;
  logic                         neg_r;
  logic [dsnp_pkg::VAL_W-1:0]   int_out_r, frac_out_r, int_trim, frac_trim;
  logic [dsnp_pkg::CNT_W-1:0]   cnt_out_r;
  dsnp_pkg::phase_t             phase_step;

  assign out_free = !out_valid_r || out_tready;
  assign take     = slot.valid && (!slot.last || out_free);
  assign out_load = take && slot.last;

  assign is_digit = (slot.code >= dsnp_pkg::CH_ZERO) && (slot.code <= dsnp_pkg::CH_NINE);
  assign digit    = {{(ACC_WIDTH-4){1'b0}}, slot.code[3:0]};
  assign int_step  = (int_acc_r << 3) + (int_acc_r << 1) + digit;
  assign frac_step = (frac_acc_r << 3) + (frac_acc_r << 1) + digit;

  always_comb begin
    phase_step    = phase_r;
    int_acc_nxt   = int_acc_r;
    frac_acc_nxt  = frac_acc_r;
    frac_cnt_step = frac_cnt_r;
    sign_step     = sign_r;
    unique case (phase_r)
      dsnp_pkg::PH_SEEK: begin
        if (is_digit) begin
          int_acc_nxt = int_step;
          phase_step  = dsnp_pkg::PH_INT;
        end else if (slot.code == dsnp_pkg::CH_MINUS) begin
          sign_step  = 1'b1;
          phase_step = dsnp_pkg::PH_INT;
        end
      end
      dsnp_pkg::PH_INT: begin
        if (is_digit) begin
          int_acc_nxt = int_step;
        end else if (slot.code == dsnp_pkg::CH_DOT) begin
          phase_step = dsnp_pkg::PH_FRAC;
        end else begin
          phase_step = dsnp_pkg::PH_DONE;
        end
      end
      dsnp_pkg::PH_FRAC: begin
        if (is_digit) begin
          frac_acc_nxt  = frac_step;
          frac_cnt_step = frac_cnt_r + 1'b1;
        end else if (slot.code != dsnp_pkg::CH_DOT) begin
          phase_step = dsnp_pkg::PH_DONE;
        end
      end
      dsnp_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // values after this character, before the end-of-string clear
  generate
    if (ACC_WIDTH >= dsnp_pkg::VAL_W) begin : g_trim
      assign int_trim  = int_acc_nxt[dsnp_pkg::VAL_W-1:0];
      assign frac_trim = frac_acc_nxt[dsnp_pkg::VAL_W-1:0];
    end else begin : g_ext
      assign int_trim  = {{(dsnp_pkg::VAL_W-ACC_WIDTH){1'b0}}, int_acc_nxt};
      assign frac_trim = {{(dsnp_pkg::VAL_W-ACC_WIDTH){1'b0}}, frac_acc_nxt};
    end
  endgenerate

  always_comb begin
    phase_nxt    = phase_r;
    frac_cnt_nxt = frac_cnt_r;
    sign_nxt     = sign_r;
    if (take) begin
      phase_nxt    = phase_step;
      frac_cnt_nxt = frac_cnt_step;
      sign_nxt     = sign_step;
      if (slot.last) begin
        phase_nxt    = dsnp_pkg::PH_SEEK;
        frac_cnt_nxt = '0;
        sign_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= dsnp_pkg::PH_SEEK;
      int_acc_r  <= '0;
      frac_acc_r <= '0;
      frac_cnt_r <= '0;
      sign_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      frac_cnt_r <= frac_cnt_nxt;
      sign_r     <= sign_nxt;
      if (take) begin
        int_acc_r  <= slot.last ? '0 : int_acc_nxt;
        frac_acc_r <= slot.last ? '0 : frac_acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= out_load;
    end
    if (out_load) begin
      neg_r      <= sign_step;
      int_out_r  <= int_trim;
      frac_out_r <= frac_trim;
      cnt_out_r  <= frac_cnt_step;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = neg_r;
  assign out_tdata  = {cnt_out_r, frac_out_r, int_out_r};

endmodule

`default_nettype wire

### rtl/decimal_string_number_parser.sv
// top level of the decimal string number parser
//
// one ascii character per slave transfer on in_tdata, with in_tlast on the
// final character of a string. leading characters are skipped until a digit
// or a minus sign; integer digits accumulate until a dot, fraction digits and
// their count follow, and the first other character ends the number.
// after the final character one master transfer carries the sign on
// out_tuser and integer part, fraction value and fraction digit count on
// out_tdata. the consumer divides the fraction by ten to the count.
// after the final character's transfer, the result passes the input register,
// then the result register.
// throughput: one character per cycle unless a final one waits; the parse
// step is a times-ten shift-add and a compare on the registered character.
// when the receiver stalls, characters that are not final keep flowing;
// a final character waits in the input register until the result register
// is free, and only then is in_tready held low.
// reset clears the parse state and both valid flags; no result is pending.
`default_nettype none

module decimal_string_number_parser #(
  parameter int ACC_WIDTH = dsnp_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [dsnp_pkg::CHAR_W-1:0]    in_tdata,   // char_code
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // integer_part, fraction_value, fraction_digits
  output logic [dsnp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser   // negative
);

  dsnp_pkg::char_slot_t slot;
  logic                 take;

  dsnp_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .take      (take),
    .slot      (slot)
  );

  dsnp_core #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot       (slot),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### rtl/dsnp_checker.sv
// port-level assertions for the decimal string number parser, bound to the top level
`default_nettype none

module dsnp_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        in_tlast,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready
);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a fresh result follows a final-character transfer through the input and result registers
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a final character");

  // input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind decimal_string_number_parser dsnp_checker u_dsnp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

### sim/decimal_string_number_parser_test.sv
// testbench for the decimal string number parser: directed and random strings checked against a predictor
`timescale 1ns / 100ps
`default_nettype none

module decimal_string_number_parser_test;

  typedef struct packed {
    logic                       negative;
    logic [dsnp_pkg::VAL_W-1:0] integer_part;
    logic [dsnp_pkg::VAL_W-1:0] fraction_value;
    logic [dsnp_pkg::CNT_W-1:0] fraction_digits;
  } parsed_number_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [dsnp_pkg::CHAR_W-1:0]     in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [dsnp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;

  parsed_number_t              pending_numbers[$];
  logic [dsnp_pkg::CHAR_W-1:0] str_buf[$];
  int unsigned                 fail_count;
  int unsigned                 chars_sent;
  bit                          tx_idle;
  bit                          rx_idle;

  // predictor state
  dsnp_pkg::phase_t            scan_phase;
  logic [dsnp_pkg::VAL_W-1:0]  int_value;
  logic [dsnp_pkg::VAL_W-1:0]  frac_value;
  logic [dsnp_pkg::CNT_W-1:0]  frac_count;
  logic                        minus_seen;

  decimal_string_number_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned draw_gap(input bit idle_on);
    if (!idle_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic clear_number();
    scan_phase = dsnp_pkg::PH_SEEK;
    int_value  = '0;
    frac_value = '0;
    frac_count = '0;
    minus_seen = 1'b0;
  endtask

  task automatic parse_char(input logic [dsnp_pkg::CHAR_W-1:0] code, input logic last);
    logic                       is_digit;
    logic [dsnp_pkg::VAL_W-1:0] digit;
    parsed_number_t             num;
    is_digit = (code >= dsnp_pkg::CH_ZERO) && (code <= dsnp_pkg::CH_NINE);
    digit    = dsnp_pkg::VAL_W'(code - dsnp_pkg::CH_ZERO);
    case (scan_phase)
      dsnp_pkg::PH_SEEK: begin
        if (is_digit) begin
          int_value  = int_value * 10 + digit;
          scan_phase = dsnp_pkg::PH_INT;
        end else if (code == dsnp_pkg::CH_MINUS) begin
          minus_seen = 1'b1;
          scan_phase = dsnp_pkg::PH_INT;
        end
      end
      dsnp_pkg::PH_INT: begin
        if (is_digit) int_value = int_value * 10 + digit;
        else if (code == dsnp_pkg::CH_DOT) scan_phase = dsnp_pkg::PH_FRAC;
        else scan_phase = dsnp_pkg::PH_DONE;
      end
      dsnp_pkg::PH_FRAC: begin
        if (is_digit) begin
          frac_value = frac_value * 10 + digit;
          frac_count = frac_count + 1'b1;
        end else if (code != dsnp_pkg::CH_DOT) begin
          scan_phase = dsnp_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
    if (last) begin
      num.negative        = minus_seen;
      num.integer_part    = int_value;
      num.fraction_value  = frac_value;
      num.fraction_digits = frac_count;
      pending_numbers.push_back(num);
      clear_number();
    end
  endtask

  // one character transfer; the predictor sees it at the accepting edge
  task automatic send_char(input logic [dsnp_pkg::CHAR_W-1:0] code, input logic last);
    int unsigned gap;
    gap = draw_gap(tx_idle);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tlast  <= last;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    parse_char(code, last);
    chars_sent++;
  endtask

  task automatic send_string();
    foreach (str_buf[i]) send_char(str_buf[i], i == str_buf.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [dsnp_pkg::CHAR_W-1:0] random_digit();
    return dsnp_pkg::CH_ZERO + dsnp_pkg::CHAR_W'($urandom_range(0, 9));
  endfunction

  task automatic build_number_string();
    int unsigned n;
    str_buf.delete();
    if ($urandom_range(0, 7) == 0) begin
      // noise
      n = $urandom_range(1, 8);
      repeat (n) str_buf.push_back(dsnp_pkg::CHAR_W'($urandom));
      return;
    end
    n = $urandom_range(0, 2);
    repeat (n) str_buf.push_back(dsnp_pkg::CHAR_W'($urandom));
    if ($urandom_range(0, 2) == 0) str_buf.push_back(dsnp_pkg::CH_MINUS);
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 5);
    repeat (n) str_buf.push_back(random_digit());
    if ($urandom_range(0, 3) != 0) begin
      str_buf.push_back(dsnp_pkg::CH_DOT);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 5);
      repeat (n) begin
        if ($urandom_range(0, 15) == 0) str_buf.push_back(dsnp_pkg::CH_DOT);
        str_buf.push_back(random_digit());
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(0, 2) == 0) str_buf.push_back(dsnp_pkg::CH_MINUS);
        else str_buf.push_back(dsnp_pkg::CHAR_W'($urandom));
      end
    end
    if (str_buf.size() == 0) str_buf.push_back(dsnp_pkg::CHAR_W'($urandom));
  endtask

  task automatic test_directed_strings();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    // skipped bytes, dot while seeking, dot right after the sign, extra dots
    str_buf = '{8'h00, dsnp_pkg::CH_DOT, dsnp_pkg::CH_MINUS, dsnp_pkg::CH_DOT, 8'h35,
                dsnp_pkg::CH_DOT, 8'h32, dsnp_pkg::CH_DOT, 8'h37, 8'hFF};
    send_string();
    // minus after the number has begun
    str_buf = '{dsnp_pkg::CH_NINE, dsnp_pkg::CH_MINUS, 8'h33};
    send_string();
    // sign with no digits, a lone zero
    str_buf = '{dsnp_pkg::CH_MINUS};
    send_string();
    str_buf = '{dsnp_pkg::CH_ZERO};
    send_string();
    // integer overflow
    str_buf = '{8'h34, dsnp_pkg::CH_NINE, dsnp_pkg::CH_NINE, dsnp_pkg::CH_NINE,
                dsnp_pkg::CH_NINE, dsnp_pkg::CH_NINE, dsnp_pkg::CH_NINE,
                dsnp_pkg::CH_NINE, dsnp_pkg::CH_NINE, dsnp_pkg::CH_NINE,
                dsnp_pkg::CH_NINE};
    send_string();
    wait_drained();
  endtask

  task automatic test_long_fraction();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    // fraction count wraps past its width
    str_buf.delete();
    str_buf.push_back(random_digit());
    str_buf.push_back(dsnp_pkg::CH_DOT);
    repeat (262) str_buf.push_back(random_digit());
    send_string();
    wait_drained();
  endtask

  task automatic test_random_strings(input int unsigned char_goal);
    int unsigned start;
    int unsigned strings;
    bit          paused;
    start   = chars_sent;
    strings = 0;
    paused  = 1'b0;
    while (chars_sent - start < char_goal) begin
      if (strings % 30 == 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      if (!paused && chars_sent - start > char_goal / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      build_number_string();
      send_string();
      strings++;
    end
    wait_drained();
  endtask

  // receiver stalls
  always begin : rx_stall
    int unsigned gap;
    gap = draw_gap(rx_idle);
    repeat (gap) begin
      @(negedge clk);
      out_tready <= 1'b0;
    end
    @(negedge clk);
    out_tready <= 1'b1;
    do @(posedge clk); while (!(out_tvalid && out_tready));
  end

  always @(posedge clk) begin : result_check
    parsed_number_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_numbers.size() == 0) begin
        $error("result transfer with no pending number");
        fail_count++;
      end else begin
        want = pending_numbers.pop_front();
        if (out_tuser !== want.negative) begin
          $error("negative: expected %0d, got %0d", want.negative, out_tuser);
          fail_count++;
        end
        if (out_tdata[dsnp_pkg::VAL_W-1:0] !== want.integer_part) begin
          $error("integer_part: expected %0d, got %0d", want.integer_part,
                 out_tdata[dsnp_pkg::VAL_W-1:0]);
          fail_count++;
        end
        if (out_tdata[2*dsnp_pkg::VAL_W-1:dsnp_pkg::VAL_W] !== want.fraction_value) begin
          $error("fraction_value: expected %0d, got %0d", want.fraction_value,
                 out_tdata[2*dsnp_pkg::VAL_W-1:dsnp_pkg::VAL_W]);
          fail_count++;
        end
        if (out_tdata[dsnp_pkg::OUT_DATA_W-1:2*dsnp_pkg::VAL_W] !== want.fraction_digits)
        begin
          $error("fraction_digits: expected %0d, got %0d", want.fraction_digits,
                 out_tdata[dsnp_pkg::OUT_DATA_W-1:2*dsnp_pkg::VAL_W]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    fail_count = 0;
    chars_sent = 0;
    tx_idle    = 1'b0;
    rx_idle    = 1'b0;
    clear_number();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_strings();
    test_long_fraction();
    test_random_strings(460);

    repeat (20) @(posedge clk);
    if (pending_numbers.size() == 0 && fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
